FILE: rtl/mkspan_pkg.sv
// Shared types, constants and helpers for the makespan evaluator.
// No dependencies; used by mkspan_ctrl, mkspan_dp and the top level.

package mkspan_pkg;

    localparam int TIME_W  = 32;
    localparam int DUR_W   = 16;
    localparam int COUNT_W = 4;

    localparam logic [COUNT_W-1:0] MACHINE_COUNT_RST = 4'd4;

    // register index decoded from paddr[2]
    localparam logic REG_MACHINE_COUNT = 1'b0;

    typedef logic [TIME_W-1:0] time_t;
    typedef logic [DUR_W-1:0]  dur_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic start;   // latch the job, reset the scan
        logic scan;    // read one machine time, compare the previous one
        logic setup;   // advance the setup resource
        logic finish;  // write the chosen machine, track the maximum
        logic emit;    // load the result register, clear the schedule
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic scan_done;  // last active machine compared this cycle
        logic last;       // current job closes the order
        logic out_busy;   // result register holds an untaken transfer
    } status_t;

    function automatic time_t sat_add(input time_t a, input dur_t b);
        logic [TIME_W:0] sum;
        begin
            sum = {1'b0, a} + {{(TIME_W-DUR_W+1){1'b0}}, b};
            sat_add = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
        end
    endfunction

endpackage

FILE: rtl/mkspan_ctrl.sv
// Sequencer for the makespan evaluator: accept, scan, setup, finish, emit.
// Depends on mkspan_pkg for the command and status structs.

module mkspan_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  mkspan_pkg::status_t status,
    output mkspan_pkg::cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_SETUP  = 3'd2;
    localparam logic [2:0] ST_FINISH = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.scan_done) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
                state_next = status.last ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                // hold until the previous result has been taken
                if (!status.out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/mkspan_dp.sv
// Datapath: machine finish-time memory, min scan, setup resource,
// running maximum and the result register. Depends on mkspan_pkg.

module mkspan_dp #(
    parameter int MAX_MACHINES = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  mkspan_pkg::cmd_t                     cmd,
    output mkspan_pkg::status_t                  status,
    input  logic [mkspan_pkg::COUNT_W-1:0]       machine_count,
    input  mkspan_pkg::dur_t                     setup_time,
    input  mkspan_pkg::dur_t                     proc_time,
    input  logic                                 last_job,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output mkspan_pkg::time_t                    m_tdata
);

    localparam int CW = $clog2(MAX_MACHINES + 1);
    localparam int IW = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
    localparam int MW = (CW > mkspan_pkg::COUNT_W) ? CW : mkspan_pkg::COUNT_W;

    mkspan_pkg::time_t mem [MAX_MACHINES];
    logic [MAX_MACHINES-1:0] valid_reg;

    mkspan_pkg::dur_t  setup_reg;
    mkspan_pkg::dur_t  proc_reg;
    logic              last_reg;
    logic [CW-1:0]     nm1_reg;
    logic [CW-1:0]     ptr_reg;
    logic [CW-1:0]     cmp_idx_reg;
    logic              cmp_vld_reg;
    mkspan_pkg::time_t rd_data_reg;
    logic              rd_hit_reg;
    mkspan_pkg::time_t min_reg;
    logic [IW-1:0]     best_reg;
    mkspan_pkg::time_t sfree_reg;
    mkspan_pkg::time_t span_reg;
    logic              m_tvalid_reg;
    mkspan_pkg::time_t m_tdata_reg;

    logic [MW-1:0]     count_ext;
    logic [CW-1:0]     active_n;
    mkspan_pkg::time_t cur_time;
    mkspan_pkg::time_t start_time;
    mkspan_pkg::time_t mach_end;

    // clamp the machine count to 1..MAX_MACHINES
    always_comb begin
        count_ext = MW'(machine_count);
        if (machine_count == '0) begin
            active_n = CW'(1);
        end else if (count_ext > MW'(MAX_MACHINES)) begin
            active_n = CW'(MAX_MACHINES);
        end else begin
            active_n = CW'(count_ext);
        end
    end

    assign cur_time   = rd_hit_reg ? rd_data_reg : '0;
    assign start_time = (min_reg > sfree_reg) ? min_reg : sfree_reg;
    assign mach_end   = mkspan_pkg::sat_add(sfree_reg, proc_reg);

    // machine finish-time memory
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            mem[best_reg] <= mach_end;
        end
        if (cmd.scan) begin
            rd_data_reg <= mem[ptr_reg[IW-1:0]];
            rd_hit_reg  <= valid_reg[ptr_reg[IW-1:0]];
        end
    end

    // job payload and scan bookkeeping
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            setup_reg <= setup_time;
            proc_reg  <= proc_time;
            last_reg  <= last_job;
            nm1_reg   <= active_n - CW'(1);
            ptr_reg   <= '0;
            min_reg   <= '1;
            best_reg  <= '0;
        end
        if (cmd.scan) begin
            ptr_reg     <= ptr_reg + CW'(1);
            cmp_idx_reg <= ptr_reg;
            if (cmp_vld_reg && (cur_time < min_reg)) begin
                min_reg  <= cur_time;
                best_reg <= cmp_idx_reg[IW-1:0];
            end
        end
        if (cmd.emit) begin
            m_tdata_reg <= span_reg;
        end
    end

    // control state of the schedule and the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            cmp_vld_reg  <= 1'b0;
            sfree_reg    <= '0;
            span_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.start) begin
                cmp_vld_reg <= 1'b0;
            end else if (cmd.scan) begin
                cmp_vld_reg <= 1'b1;
            end
            if (cmd.setup) begin
                sfree_reg <= mkspan_pkg::sat_add(start_time, setup_reg);
            end
            if (cmd.finish) begin
                valid_reg[best_reg] <= 1'b1;
                if (mach_end > span_reg) begin
                    span_reg <= mach_end;
                end
            end
            if (cmd.emit) begin
                // drop the finished order
                valid_reg    <= '0;
                sfree_reg    <= '0;
                span_reg     <= '0;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign status.scan_done = cmp_vld_reg && (cmp_idx_reg == nm1_reg);
    assign status.last      = last_reg;
    assign status.out_busy  = m_tvalid_reg && !m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: rtl/makespan_with_shared_setup.sv
// Top level of the makespan evaluator: APB register, controller, datapath.
// Depends on mkspan_pkg, mkspan_ctrl and mkspan_dp.
//
//   channel  | direction | handshake                  | payload
//   s_       | in        | s_tvalid / s_tready        | s_tdata (setup, proc), s_tlast
//   m_       | out       | m_tvalid / m_tready        | m_tdata (makespan)
//   apb      | in        | psel / penable / pready    | paddr, pwdata, prdata
//
// After its acceptance a job passes through the scan, setup and finish states before
// the next job can be accepted; the scan reads one machine time per cycle from the
// finish-time memory, one for each active machine. A last job also passes through
// the emit state to load the result register.
// Reset is synchronous; the schedule state clears at once, no clearing pass.
// A result waiting on m_tready stalls only the next last job, at its end.

module makespan_with_shared_setup #(
    parameter int MAX_MACHINES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // transfer in: [15:0] setup_time, [31:16] proc_time
    input  logic [31:0] s_tdata,
    input  logic        s_tlast,
    input  logic        s_tvalid,
    output logic        s_tready,
    // transfer out: [31:0] makespan
    output logic [31:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [mkspan_pkg::COUNT_W-1:0] machine_count_reg;
    mkspan_pkg::cmd_t    cmd;
    mkspan_pkg::status_t status;
    logic                cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == mkspan_pkg::REG_MACHINE_COUNT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            machine_count_reg <= mkspan_pkg::MACHINE_COUNT_RST;
        end else if (cfg_write) begin
            machine_count_reg <= pwdata[mkspan_pkg::COUNT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == mkspan_pkg::REG_MACHINE_COUNT) begin
            prdata = 32'(machine_count_reg);
        end
    end

    mkspan_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mkspan_dp #(
        .MAX_MACHINES (MAX_MACHINES)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .machine_count (machine_count_reg),
        .setup_time    (s_tdata[15:0]),
        .proc_time     (s_tdata[31:16]),
        .last_job      (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

    // a job in work blocks the next one
    a_one_job: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && aresetn) |=> !s_tready)
        else $error("input taken while a job is in work");

    // a register write lands in the machine count
    a_cfg_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_write && aresetn) |=> (machine_count_reg == $past(pwdata[3:0])))
        else $error("machine count write lost");

    // a result only follows a last job finishing
    a_emit_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit) |-> (status.last && !status.out_busy))
        else $error("result emitted outside a last job");

endmodule

FILE: tb/makespan_with_shared_setup_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the makespan evaluator: tracks the machine count register and
// the schedule, predicts each makespan and compares it. Depends on mkspan_pkg.

module makespan_with_shared_setup_checker #(
    parameter int MAX_MACHINES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // transfer in: [15:0] setup_time, [31:16] proc_time
    input  logic [31:0] s_tdata,
    input  logic        s_tlast,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // transfer out: [31:0] makespan
    input  logic [31:0] m_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          mismatches,
    output int          expected_left
);

    mkspan_pkg::time_t              busy_until [MAX_MACHINES];
    mkspan_pkg::time_t              setup_busy_until;
    logic [mkspan_pkg::COUNT_W-1:0] count_reg;
    mkspan_pkg::time_t              makespan_q [$];

    function automatic mkspan_pkg::time_t add_sat(input mkspan_pkg::time_t a,
                                                  input mkspan_pkg::dur_t b);
        mkspan_pkg::time_t s;
        s = a + mkspan_pkg::time_t'(b);
        return (s < a) ? '1 : s;
    endfunction

    function automatic int unsigned machines_in_use();
        if (count_reg == '0)
            return 1;
        if (int'(count_reg) > MAX_MACHINES)
            return MAX_MACHINES;
        return int'(count_reg);
    endfunction

    function automatic void clear_schedule();
        foreach (busy_until[k])
            busy_until[k] = '0;
        setup_busy_until = '0;
    endfunction

    function automatic void note_mismatch(input string what, input mkspan_pkg::time_t want,
                                          input mkspan_pkg::time_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
    endfunction

    function automatic void schedule_job(input mkspan_pkg::dur_t setup_d,
                                         input mkspan_pkg::dur_t proc_d,
                                         input logic closes);
        int unsigned       n;
        int unsigned       pick;
        mkspan_pkg::time_t start_at;
        mkspan_pkg::time_t span;
        n = machines_in_use();
        pick = 0;
        // earliest free machine, lowest index on a tie
        for (int unsigned k = 1; k < n; k++)
            if (busy_until[k] < busy_until[pick])
                pick = k;
        start_at = (busy_until[pick] > setup_busy_until) ? busy_until[pick] : setup_busy_until;
        setup_busy_until = add_sat(start_at, setup_d);
        busy_until[pick] = add_sat(setup_busy_until, proc_d);
        if (closes) begin
            // span covers every machine, also those beyond the current count
            span = '0;
            foreach (busy_until[k])
                if (busy_until[k] > span)
                    span = busy_until[k];
            makespan_q.push_back(span);
            clear_schedule();
        end
    endfunction

    always @(posedge aclk) begin : watch
        mkspan_pkg::time_t want;
        if (!aresetn) begin
            count_reg = mkspan_pkg::MACHINE_COUNT_RST;
            clear_schedule();
            makespan_q.delete();
        end else begin
            if (psel && penable && pready && paddr[2] == mkspan_pkg::REG_MACHINE_COUNT) begin
                if (pwrite)
                    count_reg = pwdata[mkspan_pkg::COUNT_W-1:0];
                else if (prdata !== {{(32-mkspan_pkg::COUNT_W){1'b0}}, count_reg})
                    note_mismatch("machine_count read", mkspan_pkg::time_t'(count_reg),
                                  prdata);
            end
            if (s_tvalid && s_tready)
                schedule_job(s_tdata[15:0], s_tdata[31:16], s_tlast);
            if (m_tvalid && m_tready) begin
                if (makespan_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: makespan %0d with no closed order", $realtime, m_tdata);
                end else begin
                    want = makespan_q.pop_front();
                    if (m_tdata !== want)
                        note_mismatch("makespan", want, m_tdata);
                end
            end
        end
        expected_left = makespan_q.size();
    end

endmodule

FILE: tb/makespan_with_shared_setup_tb.sv
`timescale 1ns / 100ps
// Testbench top for the makespan evaluator: clock, reset, job and APB stimulus,
// result back-pressure and verdict. Depends on mkspan_pkg and the checker.

module makespan_with_shared_setup_tb;

    localparam int MACHINES        = 8;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 24;
    localparam int PHASE_ITEMS     = 130;
    localparam logic [2:0] ADDR_MACHINE_COUNT = 3'd0;
    localparam logic [2:0] ADDR_UNMAPPED      = 3'd4;
    localparam logic [mkspan_pkg::COUNT_W-1:0] PHASE_COUNT [8] = '{4'd8, 4'd1, 4'd0, 4'd15,
                                                                   4'd3, 4'd9, 4'd6, 4'd5};

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic [31:0] s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        m_tready = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    wire         s_tready;
    wire  [31:0] m_tdata;
    wire         m_tvalid;
    wire  [31:0] prdata;
    wire         pready;

    bit src_gaps      = 1'b1;
    bit sink_gaps     = 1'b1;
    int hold_off_req  = 0;
    int order_left    = 0;
    int mismatches;
    int expected_left;

    always #6 aclk = ~aclk;

    makespan_with_shared_setup #(.MAX_MACHINES(MACHINES)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tlast(s_tlast), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    makespan_with_shared_setup_checker #(.MAX_MACHINES(MACHINES)) scoreboard (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tlast(s_tlast), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .mismatches(mismatches), .expected_left(expected_left)
    );

    // result side: random stalls, plus a long hold-off on request
    initial begin : result_sink
        int hold_seen;
        hold_seen = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_req != hold_seen) begin
                hold_seen = hold_off_req;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end
            m_tready <= !(sink_gaps && $urandom_range(99) < 7);
        end
    end

    task automatic send_job(input mkspan_pkg::dur_t setup_d, input mkspan_pkg::dur_t proc_d,
                            input logic closes);
        while (src_gaps && $urandom_range(99) < 7) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {proc_d, setup_d};
        s_tlast  <= closes;
        do @(posedge aclk); while (!s_tready);
    endtask

    // drop valid, wait for every makespan, then let the last job finish
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_left != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_count(input logic [mkspan_pkg::COUNT_W-1:0] value);
        apb_access(1'b1, ADDR_MACHINE_COUNT, {28'($urandom), value});
        apb_access(1'b0, ADDR_MACHINE_COUNT, '0);
    endtask

    function automatic mkspan_pkg::dur_t pick_duration();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        if (r < 18)
            return '1;
        if (r < 40)
            return mkspan_pkg::dur_t'($urandom);
        return mkspan_pkg::dur_t'($urandom_range(300));
    endfunction

    task automatic random_jobs(input int n, input int max_len);
        for (int i = 0; i < n; i++) begin
            if (order_left == 0)
                order_left = $urandom_range(max_len, 1);
            order_left--;
            send_job(pick_duration(), pick_duration(), order_left == 0);
        end
    endtask

    initial begin : stimulus
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset count of four machines
        apb_access(1'b0, ADDR_MACHINE_COUNT, '0);
        send_job('0, '0, 1'b1);
        send_job('1, '1, 1'b1);
        // ties: four equal jobs spread out, the fifth returns to machine zero
        repeat (4) send_job(16'd0, 16'd5, 1'b0);
        send_job(16'd0, 16'd1, 1'b1);
        // setup resource is the bottleneck
        repeat (2) send_job(16'd100, 16'd1, 1'b0);
        send_job(16'd100, 16'd1, 1'b1);
        send_job(16'hAAAA, 16'h5555, 1'b0);
        send_job(16'h5555, 16'hAAAA, 1'b1);
        // shrink the count mid-order: upper machines keep their times
        send_job(16'd0, 16'd10, 1'b0);
        send_job(16'd0, 16'd2000, 1'b0);
        send_job(16'd0, 16'd3000, 1'b0);
        send_job(16'd0, 16'd4000, 1'b0);
        settle();
        set_count(4'd1);
        send_job(16'd0, 16'd5, 1'b1);
        settle();
        // unmapped address: must leave the count alone
        apb_access(1'b1, ADDR_UNMAPPED, 32'hFFFF_FFF3);
        apb_access(1'b0, ADDR_MACHINE_COUNT, '0);
        repeat (2) send_job(16'd0, 16'd7, 1'b0);
        send_job(16'd0, 16'd7, 1'b1);

        for (int p = 0; p < 8; p++) begin
            settle();
            set_count(PHASE_COUNT[p]);
            src_gaps  = (p != 2);
            sink_gaps = (p != 2);
            if (p == 1)
                hold_off_req <= hold_off_req + 1;
            random_jobs(PHASE_ITEMS, (p == 1) ? 2 : 12);
        end

        settle();
        set_count(4'($urandom_range(15)));
        src_gaps = 1'b1;
        random_jobs(100, 10);

        settle();
        if (mismatches == 0 && expected_left == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
